// ===== src/mbsu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the 1-bit BMP stream unpacker: payload structs, result and
// error codes, header byte positions and configuration defaults. No dependencies.
package mbsu_pkg;

    // Field widths fixed by the stream format.
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 32;
    localparam int PIX_W      = 10;
    localparam int BIR_W      = 13;
    localparam int DEPTH_LO_W = 8;

    // Largest accepted image dimension (default for the top-level parameter).
    localparam int MAX_DIM_DEFAULT = 65535;

    // Header layout, byte positions in file order.
    localparam int HDR_OFF_LO   = 10;
    localparam int HDR_OFF_HI   = 13;
    localparam int HDR_WID_LO   = 18;
    localparam int HDR_WID_HI   = 21;
    localparam int HDR_HGT_LO   = 22;
    localparam int HDR_HGT_HI   = 25;
    localparam int HDR_DEPTH_LO = 28;
    localparam int HDR_DEPTH_HI = 29;

    // Header sanity limits.
    localparam int MIN_FILE_LEN = 62;
    localparam int MIN_DATA_OFF = 30;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 1'b1;
    localparam logic [PIX_W-1:0] DISP_W_RESET = 10'd250;
    localparam logic [PIX_W-1:0] DISP_H_RESET = 10'd122;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_HEADER = 2'd0,
        ERR_DEPTH  = 2'd1,
        ERR_TRUNC  = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
        logic [LEN_W-1:0]  image_length;
    } t_in_item;

    typedef struct packed {
        t_kind             result_kind;
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
        logic [BYTE_W-1:0] black_mask;
        t_err              error_code;
        logic              end_of_image;
    } t_out_item;

endpackage

// ===== src/mono_bmp_stream_unpacker_top.sv =====
`timescale 1ns / 1ps
// Top level of the 1-bit BMP stream unpacker: header parse, checks and
// pixel mask placement in a single registered pass. Depends on mbsu_pkg.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg      | input     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle while the output register is free or being drained; its
// result, if any, appears in the output register on the next cycle.
// The output register is the only stage: while it holds a result that is not
// taken, no new byte is accepted. Stride, row count and pixel area are kept in
// registers updated every cycle from the header words.
// Reset is synchronous and active low; no clearing pass is needed.
module mono_bmp_stream_unpacker_top #(
    parameter int MAX_DIM = mbsu_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mbsu_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mbsu_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [mbsu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbsu_pkg::PIX_W-1:0]          i_cfg_data
);
    import mbsu_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int STR_W  = DIM_W - 2;
    localparam int AREA_W = STR_W + DIM_W;
    localparam int X_W    = BIR_W + 3;

    // Configuration registers.
    logic [PIX_W-1:0] r_disp_w, r_disp_h;

    // Parser state.
    t_phase                r_phase, n_phase;
    logic [LEN_W-1:0]      r_pos, n_pos;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [LEN_W-1:0]      r_off, n_off;
    logic [LEN_W-1:0]      r_width, n_width;
    logic [LEN_W-1:0]      r_height, n_height;
    logic [DEPTH_LO_W-1:0] r_depth_lo, n_depth_lo;
    logic [DIM_W-1:0]      r_src, n_src;
    logic [BIR_W-1:0]      r_bir, n_bir;

    // Values derived from the header words, refreshed every cycle.
    logic [STR_W-1:0]  r_stride_q;
    logic [DIM_W-1:0]  r_rows_q;
    logic              r_hdr_bad_q;
    logic [AREA_W-1:0] r_area_q;

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data, n_out_data;

    // Combinational helpers.
    logic              in_accept;
    logic [LEN_W-1:0]  rows_full;
    logic [DIM_W:0]    wid_round;
    logic [4:0]        eff_pos5;
    logic [LEN_W-1:0]  eff_pos;
    t_phase            eff_phase;
    logic [1:0]        lane;
    logic [15:0]       depth_full;
    logic              too_long;
    logic              in_area;
    logic [DIM_W-1:0]  dest;
    logic [DIM_W-1:0]  disp_w_ext;
    logic [DIM_W-1:0]  limw;
    logic [X_W-1:0]    x_full;
    logic [PIX_W-1:0]  avail;
    logic [BYTE_W-1:0] mask;
    logic [BIR_W-1:0]  bir_inc;
    logic              halt;
    logic              res_valid;
    t_out_item         res;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Header-derived quantities.
    assign rows_full = r_height[LEN_W-1] ? (LEN_W'(0) - r_height) : r_height;
    assign wid_round = {1'b0, r_width[DIM_W-1:0]} + (DIM_W+1)'(31);

    always_ff @(posedge i_clk) begin
        r_stride_q  <= {wid_round[DIM_W:5], 2'b00};
        r_rows_q    <= rows_full[DIM_W-1:0];
        r_hdr_bad_q <= (r_width > LEN_W'(MAX_DIM)) || (rows_full > LEN_W'(MAX_DIM));
        r_area_q    <= AREA_W'(r_stride_q) * AREA_W'(r_rows_q);
    end

    // Effective position and phase for the byte on the input.
    assign eff_pos   = i_in_data.first_byte ? '0 : r_pos;
    assign eff_pos5  = eff_pos[4:0];
    assign eff_phase = i_in_data.first_byte ? PH_HEADER : r_phase;
    assign lane      = eff_pos5[1:0] - 2'((HDR_OFF_LO % 4));

    // Header checks at the last header byte.
    assign depth_full = {i_in_data.data_byte, r_depth_lo};
    assign too_long   = ({1'b0, r_off} + (LEN_W+1)'(r_area_q)) > {1'b0, r_len};

    // Pixel placement in the data phase.
    assign in_area    = (r_pos >= r_off) && (r_stride_q != '0) && (r_src < r_rows_q);
    assign dest       = r_height[LEN_W-1] ? r_src : (r_rows_q - DIM_W'(1) - r_src);
    assign disp_w_ext = DIM_W'(r_disp_w);
    assign limw       = (r_width[DIM_W-1:0] < disp_w_ext) ? r_width[DIM_W-1:0] : disp_w_ext;
    assign x_full     = {r_bir, 3'b000};
    assign avail      = PIX_W'(limw) - x_full[PIX_W-1:0];
    assign bir_inc    = r_bir + BIR_W'(1);

    always_comb begin
        mask = ~i_in_data.data_byte;
        if (avail < PIX_W'(8)) begin
            mask = mask & ~(8'hFF >> avail[2:0]);
        end
    end

    // Next-state and result logic for one transfer.
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_len       = r_len;
        n_off       = r_off;
        n_width     = r_width;
        n_height    = r_height;
        n_depth_lo  = r_depth_lo;
        n_src       = r_src;
        n_bir       = r_bir;
        res         = '0;
        res_valid   = 1'b0;
        halt        = 1'b0;

        if (in_accept) begin
            // Start of a new image restarts the parser.
            if (i_in_data.first_byte) begin
                n_off      = '0;
                n_width    = '0;
                n_height   = '0;
                n_depth_lo = '0;
                n_src      = '0;
                n_bir      = '0;
                n_len      = i_in_data.image_length;
                n_phase    = PH_HEADER;
                if (i_in_data.image_length < LEN_W'(MIN_FILE_LEN)) begin
                    res.result_kind  = KIND_ERROR;
                    res.error_code   = ERR_HEADER;
                    res.end_of_image = 1'b1;
                    res_valid        = 1'b1;
                    n_phase          = PH_IDLE;
                    halt             = 1'b1;
                end
            end

            if (!halt) begin
                case (eff_phase)
                    PH_HEADER: begin
                        // Gather the little-endian header words.
                        case (eff_pos5) inside
                            [HDR_OFF_LO:HDR_OFF_HI]: n_off[{lane, 3'b000} +: 8] =
                                i_in_data.data_byte;
                            [HDR_WID_LO:HDR_WID_HI]: n_width[{lane, 3'b000} +: 8] =
                                i_in_data.data_byte;
                            [HDR_HGT_LO:HDR_HGT_HI]: n_height[{lane, 3'b000} +: 8] =
                                i_in_data.data_byte;
                            HDR_DEPTH_LO: n_depth_lo = i_in_data.data_byte;
                            default: ;
                        endcase

                        if (eff_pos5 == 5'(HDR_DEPTH_HI)) begin
                            res.end_of_image = 1'b1;
                            res_valid        = 1'b1;
                            if (depth_full != 16'd1) begin
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_DEPTH;
                                n_phase         = PH_IDLE;
                                halt            = 1'b1;
                            end else if ((r_off < LEN_W'(MIN_DATA_OFF)) || r_hdr_bad_q) begin
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_HEADER;
                                n_phase         = PH_IDLE;
                                halt            = 1'b1;
                            end else if (too_long) begin
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_TRUNC;
                                n_phase         = PH_IDLE;
                                halt            = 1'b1;
                            end else begin
                                res.result_kind  = KIND_CLEAR;
                                res.end_of_image = 1'b0;
                                n_phase          = PH_DATA;
                            end
                        end else if (i_in_data.last_byte) begin
                            // The file ended inside the header.
                            res.result_kind  = KIND_ERROR;
                            res.error_code   = ERR_HEADER;
                            res.end_of_image = 1'b1;
                            res_valid        = 1'b1;
                            n_phase          = PH_IDLE;
                            halt             = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        if (in_area) begin
                            // Visible bytes become a pixel group; padding is dropped.
                            if ((32'(x_full) < 32'(limw)) && (dest < DIM_W'(r_disp_h))) begin
                                res.result_kind = KIND_PIXEL;
                                res.pixel_x     = x_full[PIX_W-1:0];
                                res.pixel_y     = dest[PIX_W-1:0];
                                res.black_mask  = mask;
                                res_valid       = 1'b1;
                            end
                            if (32'(bir_inc) >= 32'(r_stride_q)) begin
                                n_bir = '0;
                                n_src = r_src + DIM_W'(1);
                            end else begin
                                n_bir = bir_inc;
                            end
                        end
                    end
                    default: begin
                        // Idle: bytes outside an image are ignored.
                        halt = 1'b1;
                    end
                endcase
            end

            if (!halt) begin
                n_pos = (eff_pos == '1) ? eff_pos : eff_pos + LEN_W'(1);
                if (i_in_data.last_byte) begin
                    if (res_valid) begin
                        res.end_of_image = 1'b1;
                    end else begin
                        res              = '0;
                        res.result_kind  = KIND_DONE;
                        res.end_of_image = 1'b1;
                        res_valid        = 1'b1;
                    end
                    n_phase = PH_IDLE;
                end
            end
        end

        // Output register: load a new result, or drop one that was taken.
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        if (res_valid) begin
            n_out_valid = 1'b1;
            n_out_data  = res;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
            r_disp_w    <= DISP_W_RESET;
            r_disp_h    <= DISP_H_RESET;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DISPLAY_WIDTH:  r_disp_w <= i_cfg_data;
                    CFG_DISPLAY_HEIGHT: r_disp_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Parser words and the output payload.
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_len      <= n_len;
        r_off      <= n_off;
        r_width    <= n_width;
        r_height   <= n_height;
        r_depth_lo <= n_depth_lo;
        r_src      <= n_src;
        r_bir      <= n_bir;
        r_out_data <= n_out_data;
    end

    // Every error ends the image.
    a_error_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.result_kind == KIND_ERROR)) |->
            r_out_data.end_of_image)
        else $error("error result without end of image");

    // An image-done marker always carries the end flag and no pixels.
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.result_kind == KIND_DONE)) |->
            (r_out_data.end_of_image && (r_out_data.black_mask == '0)))
        else $error("done result malformed");

    // Pixel groups lie inside the panel.
    a_pixel_on_panel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.result_kind == KIND_PIXEL)) |->
            ((r_out_data.pixel_x < r_disp_w) && (r_out_data.pixel_y < r_disp_h)))
        else $error("pixel group outside the panel");

    // The last byte of a file always returns the parser to idle.
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.last_byte) |=> (r_phase == PH_IDLE))
        else $error("parser not idle after last byte");

endmodule

// ===== verif/tb_mono_bmp_stream_unpacker_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mono_bmp_stream_unpacker_top: drives whole BMP files byte by
// byte and checks every result against the byte-level decoder model kept in this file
// or an error typed in by hand. Depends on mbsu_pkg and the unpacker top level.
module tb_mono_bmp_stream_unpacker_top;
    import mbsu_pkg::*;

    localparam int unsigned DIM_LIMIT    = MAX_DIM_DEFAULT;
    localparam int          RANDOM_BYTES = 300;
    localparam int          IDLE_PCT     = 27;
    localparam int          STALL_LIMIT  = 2000;

    // One directed file: header fields, bytes to send (0 means the whole file),
    // whether the last byte is flagged, and an error typed in by hand.
    typedef struct packed {
        logic [31:0] len;
        logic [31:0] off;
        logic [31:0] wid;
        logic [31:0] hgt;
        logic [15:0] depth;
        logic [31:0] nbytes;
        logic        with_last;
        logic        typed;
        t_err        code;
    } t_scenario;

    localparam int NUM_DIRECTED = 27;

    t_scenario directed_files [NUM_DIRECTED] = '{
        // Short claimed length, alone and with the last flag.
        '{32'd0,   32'd62, 32'd8, 32'd1, 16'd1, 32'd1,  1'b0, 1'b1, ERR_HEADER},
        '{32'd61,  32'd62, 32'd8, 32'd1, 16'd1, 32'd1,  1'b1, 1'b1, ERR_HEADER},
        // File that ends on its first byte, then ends inside the header.
        '{32'd100, 32'd62, 32'd8, 32'd1, 16'd1, 32'd1,  1'b1, 1'b1, ERR_HEADER},
        '{32'd200, 32'd62, 32'd8, 32'd1, 16'd1, 32'd12, 1'b1, 1'b1, ERR_HEADER},
        '{32'd200, 32'd62, 32'd8, 32'd1, 16'd1, 32'd29, 1'b1, 1'b1, ERR_HEADER},
        // Bit counts other than one.
        '{32'd200, 32'd62, 32'd8, 32'd1, 16'd24,     32'd30, 1'b0, 1'b1, ERR_DEPTH},
        '{32'd200, 32'd62, 32'd8, 32'd1, 16'h0101,   32'd30, 1'b0, 1'b1, ERR_DEPTH},
        '{32'd200, 32'd62, 32'd8, 32'd1, 16'd0,      32'd30, 1'b0, 1'b1, ERR_DEPTH},
        // Bad offset and oversize dimensions.
        '{32'd200, 32'd29, 32'd8,          32'd1, 16'd1, 32'd30, 1'b0, 1'b1, ERR_HEADER},
        '{32'd200, 32'd62, 32'h0001_0000,  32'd1, 16'd1, 32'd30, 1'b0, 1'b1, ERR_HEADER},
        '{32'd200, 32'd62, 32'h8000_0000,  32'd1, 16'd1, 32'd30, 1'b0, 1'b1, ERR_HEADER},
        '{32'd200, 32'd62, 32'd8, 32'h0001_0000, 16'd1, 32'd30, 1'b0, 1'b1, ERR_HEADER},
        '{32'd200, 32'd62, 32'd8, 32'hFFFF_0000, 16'd1, 32'd30, 1'b0, 1'b1, ERR_HEADER},
        '{32'd200, 32'd62, 32'd8, 32'h8000_0000, 16'd1, 32'd30, 1'b0, 1'b1, ERR_HEADER},
        // Pixel area past the claimed length.
        '{32'd100, 32'd62, 32'd32, 32'd10, 16'd1, 32'd30, 1'b0, 1'b1, ERR_TRUNC},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd8, 32'd1, 16'd1, 32'd30, 1'b0, 1'b1, ERR_TRUNC},
        // File cut off without a last flag; the next file restarts the parser.
        '{32'd200, 32'd30, 32'd16, 32'd4, 16'd1, 32'd38, 1'b0, 1'b0, ERR_HEADER},
        // Well-formed files checked against the decoder model.
        '{32'd62,  32'd30, 32'd1,   32'd8,         16'd1, 32'd0,  1'b1, 1'b0, ERR_HEADER},
        '{32'd62,  32'd30, 32'd32,  32'd2,         16'd1, 32'd0,  1'b1, 1'b0, ERR_HEADER},
        '{32'd64,  32'd30, 32'd20,  32'hFFFF_FFFB, 16'd1, 32'd0,  1'b1, 1'b0, ERR_HEADER},
        '{32'd200, 32'd54, 32'd300, 32'd3,         16'd1, 32'd94, 1'b1, 1'b0, ERR_HEADER},
        '{32'd100, 32'd40, 32'd0,   32'd4,         16'd1, 32'd48, 1'b1, 1'b0, ERR_HEADER},
        '{32'd62,  32'd30, 32'd16,  32'd0,         16'd1, 32'd34, 1'b1, 1'b0, ERR_HEADER},
        '{32'd62,  32'd30, 32'd8,   32'd2,         16'd1, 32'd48, 1'b1, 1'b0, ERR_HEADER},
        '{32'hFFFF_FFFF, 32'd62, 32'd65535, 32'd2, 16'd1, 32'd70,  1'b1, 1'b0, ERR_HEADER},
        '{32'hFFFF_FFFF, 32'd30, 32'd1, 32'd65535, 16'd1, 32'd40,  1'b1, 1'b0, ERR_HEADER},
        '{32'd534, 32'd30, 32'd1,   32'd126,       16'd1, 32'd62, 1'b1, 1'b0, ERR_HEADER}
    };

    // Block ports.
    logic             clk;
    logic             rst_n;
    logic             tx_valid;
    logic             in_ready;
    t_in_item         tx_item;
    logic             out_valid;
    logic             rx_ready = 1'b0;
    t_out_item        out_item;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PIX_W-1:0] cfg_data;

    // Decoder model state.
    logic [PIX_W-1:0] disp_w;
    logic [PIX_W-1:0] disp_h;
    logic [31:0]      hdr_pos;
    logic [31:0]      hdr_len;
    logic [31:0]      hdr_off;
    logic [31:0]      hdr_wid;
    logic [31:0]      hdr_hgt;
    logic [15:0]      hdr_depth;
    logic [15:0]      src_row;
    logic [BIR_W-1:0] row_byte;
    t_phase           parse_state;

    // Results still owed by the block, oldest first.
    t_out_item pending_results [$];
    t_out_item oldest;

    bit stall_enable;
    int mismatch_count;
    int results_checked;
    int bytes_decoded;
    int images_sent;
    int kind_count [4];

    mono_bmp_stream_unpacker_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tx_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (tx_item),
        .o_out_valid (out_valid),
        .i_out_ready (rx_ready),
        .o_out_data  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] row_total(input logic [31:0] h);
        return h[31] ? (32'd0 - h) : h;
    endfunction

    function automatic logic [31:0] row_bytes(input logic [31:0] w);
        return ((w + 32'd31) >> 5) << 2;
    endfunction

    function automatic t_out_item error_result(input t_err code);
        t_out_item r;
        begin
            r = '0;
            r.result_kind  = KIND_ERROR;
            r.error_code   = code;
            r.end_of_image = 1'b1;
            return r;
        end
    endfunction

    // Decode one accepted byte; has is set when the byte yields a result.
    function automatic void decode_byte(input t_in_item it, output bit has,
                                        output t_out_item res);
        logic [31:0] b32;
        logic [31:0] pos;
        logic [31:0] rows;
        logic [31:0] stride;
        logic [31:0] dest;
        logic [31:0] limw;
        logic [31:0] x;
        logic [31:0] avail;
        logic [7:0]  mask;
        begin
            b32 = {24'd0, it.data_byte};
            has = 1'b0;
            res = '0;

            // A first byte restarts everything and samples the claimed length.
            if (it.first_byte) begin
                hdr_pos     = '0;
                hdr_off     = '0;
                hdr_wid     = '0;
                hdr_hgt     = '0;
                hdr_depth   = '0;
                src_row     = '0;
                row_byte    = '0;
                hdr_len     = it.image_length;
                parse_state = PH_HEADER;
                if (hdr_len < MIN_FILE_LEN) begin
                    res = error_result(ERR_HEADER);
                    has = 1'b1;
                    parse_state = PH_IDLE;
                    return;
                end
            end

            if (parse_state == PH_HEADER) begin
                pos = hdr_pos;
                if (pos >= HDR_OFF_LO && pos <= HDR_OFF_HI)
                    hdr_off = hdr_off | (b32 << (8 * (pos - HDR_OFF_LO)));
                else if (pos >= HDR_WID_LO && pos <= HDR_WID_HI)
                    hdr_wid = hdr_wid | (b32 << (8 * (pos - HDR_WID_LO)));
                else if (pos >= HDR_HGT_LO && pos <= HDR_HGT_HI)
                    hdr_hgt = hdr_hgt | (b32 << (8 * (pos - HDR_HGT_LO)));
                else if (pos >= HDR_DEPTH_LO && pos <= HDR_DEPTH_HI)
                    hdr_depth = hdr_depth | (16'(it.data_byte) << (8 * (pos - HDR_DEPTH_LO)));

                if (pos == HDR_DEPTH_HI) begin
                    // Header complete: bit count first, then sizes, then the area.
                    rows   = row_total(hdr_hgt);
                    stride = row_bytes(hdr_wid);
                    if (hdr_depth != 16'd1) begin
                        res = error_result(ERR_DEPTH);
                        has = 1'b1;
                        parse_state = PH_IDLE;
                        return;
                    end
                    if (hdr_off < MIN_DATA_OFF || hdr_wid > DIM_LIMIT || rows > DIM_LIMIT) begin
                        res = error_result(ERR_HEADER);
                        has = 1'b1;
                        parse_state = PH_IDLE;
                        return;
                    end
                    if ({32'd0, hdr_off} + {32'd0, stride} * {32'd0, rows} > {32'd0, hdr_len})
                    begin
                        res = error_result(ERR_TRUNC);
                        has = 1'b1;
                        parse_state = PH_IDLE;
                        return;
                    end
                    res.result_kind = KIND_CLEAR;
                    has = 1'b1;
                    parse_state = PH_DATA;
                end else if (it.last_byte) begin
                    res = error_result(ERR_HEADER);
                    has = 1'b1;
                    parse_state = PH_IDLE;
                    return;
                end
            end else if (parse_state == PH_DATA) begin
                rows   = row_total(hdr_hgt);
                stride = row_bytes(hdr_wid);
                if (hdr_pos >= hdr_off && stride != 0 && {16'd0, src_row} < rows) begin
                    // Bottom-up files put the first stored row at the bottom.
                    dest = hdr_hgt[31] ? {16'd0, src_row} : rows - 32'd1 - {16'd0, src_row};
                    limw = (hdr_wid < {22'd0, disp_w}) ? hdr_wid : {22'd0, disp_w};
                    x    = {16'd0, row_byte, 3'b000};
                    if (x < limw && dest < {22'd0, disp_h}) begin
                        mask  = ~it.data_byte;
                        avail = limw - x;
                        if (avail < 8)
                            mask = mask & (8'hFF << (8 - avail));
                        res.result_kind = KIND_PIXEL;
                        res.pixel_x     = x[PIX_W-1:0];
                        res.pixel_y     = dest[PIX_W-1:0];
                        res.black_mask  = mask;
                        has = 1'b1;
                    end
                    row_byte = row_byte + 1'b1;
                    if ({19'd0, row_byte} >= stride) begin
                        row_byte = '0;
                        src_row  = src_row + 16'd1;
                    end
                end
            end else begin
                return;
            end

            if (hdr_pos != 32'hFFFF_FFFF)
                hdr_pos = hdr_pos + 32'd1;

            // The last byte always closes the image with an end flag.
            if (it.last_byte) begin
                if (has) begin
                    res.end_of_image = 1'b1;
                end else begin
                    res = '0;
                    res.result_kind  = KIND_DONE;
                    res.end_of_image = 1'b1;
                    has = 1'b1;
                end
                parse_state = PH_IDLE;
            end
        end
    endfunction

    // Offer one byte, wait for its transfer and record what it should yield.
    // Called and returns at a falling edge.
    task automatic push_byte(input t_in_item it, input bit typed, input t_out_item typed_res);
        bit        has;
        t_out_item res;
        begin
            while (stall_enable && $urandom_range(99) < IDLE_PCT) begin
                tx_valid <= 1'b0;
                @(negedge clk);
            end
            tx_valid <= 1'b1;
            tx_item  <= it;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            if (parse_state != PH_IDLE || it.first_byte)
                bytes_decoded++;
            decode_byte(it, has, res);
            if (typed)
                pending_results.push_back(typed_res);
            else if (has)
                pending_results.push_back(res);
            @(negedge clk);
        end
    endtask

    // Hold the sender back until every owed result has come out.
    task automatic drain_results();
        begin
            tx_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic write_display(input logic [PIX_W-1:0] w, input logic [PIX_W-1:0] h);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_DISPLAY_WIDTH;
            cfg_data  <= w;
            @(negedge clk);
            cfg_index <= CFG_DISPLAY_HEIGHT;
            cfg_data  <= h;
            @(negedge clk);
            cfg_we <= 1'b0;
            disp_w = w;
            disp_h = h;
        end
    endtask

    function automatic logic [PIX_W-1:0] pick_dim();
        case ($urandom_range(4))
            0:       return 10'd1;
            1:       return 10'd1023;
            2:       return 10'($urandom_range(1, 16));
            3:       return 10'($urandom_range(1, 80));
            default: return 10'($urandom_range(1, 1023));
        endcase
    endfunction

    // Send one file: header fields at their positions, everything else random.
    task automatic send_image(input logic [31:0] len, input logic [31:0] off,
                              input logic [31:0] wid, input logic [31:0] hgt,
                              input logic [15:0] depth, input logic [31:0] nbytes,
                              input bit with_last, input bit typed, input t_err code);
        logic [31:0] total;
        logic [31:0] p;
        t_in_item    it;
        begin
            total = (nbytes != 0) ? nbytes : off + row_bytes(wid) * row_total(hgt);
            for (p = 0; p < total; p++) begin
                if (p >= HDR_OFF_LO && p <= HDR_OFF_HI)
                    it.data_byte = 8'(off >> (8 * (p - HDR_OFF_LO)));
                else if (p >= HDR_WID_LO && p <= HDR_WID_HI)
                    it.data_byte = 8'(wid >> (8 * (p - HDR_WID_LO)));
                else if (p >= HDR_HGT_LO && p <= HDR_HGT_HI)
                    it.data_byte = 8'(hgt >> (8 * (p - HDR_HGT_LO)));
                else if (p >= HDR_DEPTH_LO && p <= HDR_DEPTH_HI)
                    it.data_byte = 8'(depth >> (8 * (p - HDR_DEPTH_LO)));
                else begin
                    // Plenty of all-white and all-black bytes among the random ones.
                    case ($urandom_range(3))
                        0:       it.data_byte = 8'h00;
                        1:       it.data_byte = 8'hFF;
                        default: it.data_byte = 8'($urandom);
                    endcase
                end
                it.first_byte   = (p == 0);
                it.last_byte    = with_last && (p == total - 1);
                it.image_length = (p == 0) ? len : $urandom;
                push_byte(it, typed && (p == total - 1), error_result(code));
            end
            images_sent++;
        end
    endtask

    // Mostly small well-formed files; about a third carry one defect.
    task automatic random_image();
        logic [31:0] len;
        logic [31:0] off;
        logic [31:0] wid;
        logic [31:0] hgt;
        logic [31:0] rows;
        logic [31:0] full;
        logic [31:0] nbytes;
        logic [15:0] depth;
        bit          with_last;
        t_in_item    stray;
        begin
            // Stray bytes between files; ignored unless a file was left open.
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    stray.data_byte    = 8'($urandom);
                    stray.first_byte   = 1'b0;
                    stray.last_byte    = 1'($urandom_range(1));
                    stray.image_length = $urandom;
                    push_byte(stray, 1'b0, '0);
                end
            end

            case ($urandom_range(19))
                0:       wid = 32'd0;
                1:       wid = $urandom_range(200, 1100);
                default: wid = $urandom_range(1, 72);
            endcase
            rows      = (wid > 100) ? $urandom_range(1, 2) : $urandom_range(0, 6);
            hgt       = $urandom_range(1) ? rows : (32'd0 - rows);
            off       = ($urandom_range(3) == 0) ? $urandom_range(46, 70) : $urandom_range(30, 40);
            full      = off + row_bytes(wid) * rows;
            len       = full + $urandom_range(0, 16);
            if (len < MIN_FILE_LEN)
                len = MIN_FILE_LEN + $urandom_range(0, 8);
            depth     = 16'd1;
            nbytes    = full + $urandom_range(0, 3);
            with_last = 1'b1;

            if ($urandom_range(99) < 30) begin
                case ($urandom_range(6))
                    0: depth = 16'($urandom);
                    1: off = $urandom_range(0, 40);
                    2: len = $urandom;
                    3: nbytes = $urandom_range(1, 30);
                    4: begin
                        nbytes    = $urandom_range(30, full);
                        with_last = 1'b0;
                    end
                    5: begin
                        wid    = $urandom;
                        nbytes = 32'd30;
                    end
                    default: begin
                        hgt    = $urandom;
                        nbytes = 32'd30;
                    end
                endcase
            end
            send_image(len, off, wid, hgt, depth, nbytes, with_last, 1'b0, ERR_HEADER);
        end
    endtask

    // Receiver: random backpressure, changed at the falling edge.
    always @(negedge clk)
        rx_ready <= stall_enable ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

    task automatic compare_field(input string name, input logic [9:0] want,
                                 input logic [9:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Check every result transfer against the oldest owed result.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && rx_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected, expected none actual %h",
                         $time, out_item);
            end else begin
                oldest = pending_results.pop_front();
                compare_field("result_kind",  oldest.result_kind,  out_item.result_kind);
                compare_field("pixel_x",      oldest.pixel_x,      out_item.pixel_x);
                compare_field("pixel_y",      oldest.pixel_y,      out_item.pixel_y);
                compare_field("black_mask",   oldest.black_mask,   out_item.black_mask);
                compare_field("error_code",   oldest.error_code,   out_item.error_code);
                compare_field("end_of_image", oldest.end_of_image, out_item.end_of_image);
                results_checked++;
                kind_count[oldest.result_kind]++;
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (tx_valid && in_ready) || (out_valid === 1'b1 && rx_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb_mono_bmp_stream_unpacker_top NOT OK");
        $finish;
    end

    // Main sequence: reset, directed files, then random files and settings.
    initial begin
        int start_bytes;
        int rand_images;
        rst_n        = 1'b0;
        tx_valid     = 1'b0;
        tx_item      = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_DISPLAY_WIDTH;
        cfg_data     = '0;
        stall_enable = 1'b1;
        disp_w       = DISP_W_RESET;
        disp_h       = DISP_H_RESET;
        hdr_pos      = '0;
        hdr_len      = '0;
        hdr_off      = '0;
        hdr_wid      = '0;
        hdr_hgt      = '0;
        hdr_depth    = '0;
        src_row      = '0;
        row_byte     = '0;
        parse_state  = PH_IDLE;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed files run at the reset display size.
        foreach (directed_files[i])
            send_image(directed_files[i].len, directed_files[i].off, directed_files[i].wid,
                       directed_files[i].hgt, directed_files[i].depth,
                       directed_files[i].nbytes, directed_files[i].with_last,
                       directed_files[i].typed, directed_files[i].code);
        drain_results();
        write_display(10'd1023, 10'd1);

        // Random files; a quiet stretch without idling on either side.
        start_bytes = bytes_decoded;
        rand_images = 0;
        while (bytes_decoded - start_bytes < RANDOM_BYTES) begin
            if ($urandom_range(3) == 0) begin
                drain_results();
                write_display(pick_dim(), pick_dim());
            end
            stall_enable = !(rand_images >= 1 && rand_images < 4);
            random_image();
            rand_images++;
        end
        stall_enable = 1'b1;

        drain_results();
        repeat (8) @(negedge clk);

        $display("Sent %0d files, %0d decoded bytes; checked %0d results", images_sent,
                 bytes_decoded, results_checked);
        $display("(%0d pixel groups, %0d errors, %0d clears, %0d done markers).",
                 kind_count[KIND_PIXEL], kind_count[KIND_ERROR], kind_count[KIND_CLEAR],
                 kind_count[KIND_DONE]);
        if (mismatch_count == 0)
            $display("tb_mono_bmp_stream_unpacker_top OK");
        else
            $display("tb_mono_bmp_stream_unpacker_top NOT OK");
        $finish;
    end

endmodule
